// ----- rtl/interval_and_bounds_top_assert.svh -----
// ----------------------------------------------------------------------------
// interval_and_bounds_top_assert: assertion macros
// shared property forms used by the port checker
// ----------------------------------------------------------------------------
`ifndef INTERVAL_AND_BOUNDS_TOP_ASSERT_SVH
`define INTERVAL_AND_BOUNDS_TOP_ASSERT_SVH

// same-cycle implication, disabled in reset
`define IAB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define IAB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/iab_pkg.sv -----
// ----------------------------------------------------------------------------
// iab_pkg
// types and constants shared by the interval and-bounds block
// ----------------------------------------------------------------------------
package iab_pkg;

  localparam int NUM_LANES = 4;
  localparam int LANE_W    = 2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_COMB,
    S_EMIT
  } iab_state_t;

  typedef struct packed {
    logic              load;
    logic              step;
    logic              comb;
    logic              emit;
    logic [LANE_W-1:0] lane;
  } iab_ctrl_t;

endpackage

// ----- rtl/iab_scan.sv -----
// ----------------------------------------------------------------------------
// iab_scan
// one pair of sign-uniform ranges: bit-serial search for the unsigned
// minimum and maximum of x AND y for x in [a, b], y in [c, d], one bit position per step
// ----------------------------------------------------------------------------
module iab_scan #(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  logic             step,
  input  logic [WIDTH-1:0] m,
  input  logic [WIDTH-1:0] a_in,
  input  logic [WIDTH-1:0] b_in,
  input  logic [WIDTH-1:0] c_in,
  input  logic [WIDTH-1:0] d_in,
  output logic [WIDTH-1:0] lo_res,
  output logic [WIDTH-1:0] hi_res
);

  // fixed range bounds
  logic [WIDTH-1:0] a0, b0, c0, d0;
  // bounds moved by the search
  logic [WIDTH-1:0] as, bs, cs, ds;
  logic             fmin, fmax;

  logic [WIDTH-1:0] lowm, highm, t1, t2, t3, t4;

  always_comb begin
    lowm  = m - 1'b1;
    highm = ~lowm;
    t1    = (as | m) & highm;
    t2    = (cs | m) & highm;
    t3    = (bs & ~m) | lowm;
    t4    = (ds & ~m) | lowm;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fmin <= 1'b0;
      fmax <= 1'b0;
    end else if (load) begin
      fmin <= 1'b0;
      fmax <= 1'b0;
    end else if (step) begin
      if (!fmin && (|(~as & ~cs & m))) begin
        if (t1 <= b0) begin
          fmin <= 1'b1;
        end else if (t2 <= d0) begin
          fmin <= 1'b1;
        end
      end
      if (!fmax) begin
        if (|(bs & ~ds & m)) begin
          if (t3 >= a0) begin
            fmax <= 1'b1;
          end
        end else if (|(~bs & ds & m)) begin
          if (t4 >= c0) begin
            fmax <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      a0 <= a_in;
      b0 <= b_in;
      c0 <= c_in;
      d0 <= d_in;
      as <= a_in;
      bs <= b_in;
      cs <= c_in;
      ds <= d_in;
    end else if (step) begin
      if (!fmin && (|(~as & ~cs & m))) begin
        if (t1 <= b0) begin
          as <= t1;
        end else if (t2 <= d0) begin
          cs <= t2;
        end
      end
      if (!fmax) begin
        if (|(bs & ~ds & m)) begin
          if (t3 >= a0) begin
            bs <= t3;
          end
        end else if (|(~bs & ds & m)) begin
          if (t4 >= c0) begin
            ds <= t4;
          end
        end
      end
    end
  end

  assign lo_res = as & cs;
  assign hi_res = bs & ds;

endmodule

// ----- rtl/iab_seq.sv -----
// ----------------------------------------------------------------------------
// iab_seq
// sequencer: load, bit scan from the top down, lane combine, emit
// ----------------------------------------------------------------------------
module iab_seq #(
  parameter int WIDTH = 32,
  parameter int BW    = $clog2(WIDTH)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  logic             out_busy,
  output iab_pkg::iab_ctrl_t ctrl,
  output logic [BW-1:0]    bit_pos
);
  import iab_pkg::*;

  iab_state_t        state, state_next;
  logic [BW-1:0]     bit_pos_next;
  logic [LANE_W-1:0] lane_sel, lane_sel_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      bit_pos  <= '0;
      lane_sel <= '0;
    end else begin
      state    <= state_next;
      bit_pos  <= bit_pos_next;
      lane_sel <= lane_sel_next;
    end
  end

  always_comb begin
    state_next    = state;
    bit_pos_next  = bit_pos;
    lane_sel_next = lane_sel;
    req_ready     = 1'b0;
    ctrl          = '0;
    ctrl.lane     = lane_sel;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          ctrl.load    = 1'b1;
          bit_pos_next = BW'(WIDTH - 1);
          state_next   = S_SCAN;
        end
      end
      S_SCAN: begin
        ctrl.step = 1'b1;
        if (bit_pos == '0) begin
          lane_sel_next = '0;
          state_next    = S_COMB;
        end else begin
          bit_pos_next = bit_pos - 1'b1;
        end
      end
      S_COMB: begin
        ctrl.comb = 1'b1;
        if (lane_sel == LANE_W'(NUM_LANES - 1)) begin
          state_next = S_EMIT;
        end else begin
          lane_sel_next = lane_sel + 1'b1;
        end
      end
      S_EMIT: begin
        if (!out_busy) begin
          ctrl.emit  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/interval_and_bounds_top.sv -----
// sequence: an accepted request runs WIDTH scan steps, four lane combine steps and
// one emit step; the emit step waits while a response is stalled, and the bit
// scan walks one position per step; not ready while a request is in work
// reset: synchronous, active high; clears sequencer and result valid, no sweep
// ----------------------------------------------------------------------------
// interval_and_bounds_top
// exact signed minimum and maximum of i AND j over two signed intervals
// ----------------------------------------------------------------------------
module interval_and_bounds_top #(
  parameter int WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  logic signed [31:0] x_low,
  input  logic signed [31:0] x_high,
  input  logic               x_void,
  input  logic signed [31:0] y_low,
  input  logic signed [31:0] y_high,
  input  logic               y_void,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output logic signed [31:0] z_low,
  output logic signed [31:0] z_high,
  output logic               z_void
);
  import iab_pkg::*;

  localparam int BW = $clog2(WIDTH);
  localparam logic [WIDTH-1:0] TopBit = {1'b1, {(WIDTH-1){1'b0}}};

  iab_ctrl_t     ctrl;
  logic [BW-1:0] bit_pos;
  logic          out_busy;

  // inputs sign extended, then wrapped to the datapath width
  logic signed [63:0] x0_ext, x1_ext, y0_ext, y1_ext;
  logic [WIDTH-1:0]   xw0, xw1, yw0, yw1;
  logic               empty_in;

  assign x0_ext = 64'(x_low);
  assign x1_ext = 64'(x_high);
  assign y0_ext = 64'(y_low);
  assign y1_ext = 64'(y_high);
  assign xw0    = x0_ext[WIDTH-1:0];
  assign xw1    = x1_ext[WIDTH-1:0];
  assign yw0    = y0_ext[WIDTH-1:0];
  assign yw1    = y1_ext[WIDTH-1:0];

  // void flag or inverted range gives an empty result
  assign empty_in = x_void || y_void
                    || ($signed(xw0) > $signed(xw1))
                    || ($signed(yw0) > $signed(yw1));

  // sign split: part 0 is the negative part, part 1 the non-negative part
  logic [WIDTH-1:0] xl [2];
  logic [WIDTH-1:0] xh [2];
  logic [WIDTH-1:0] yl [2];
  logic [WIDTH-1:0] yh [2];
  logic [1:0]       xv, yv;

  always_comb begin
    xl[0] = xw0;
    xh[0] = xw1[WIDTH-1] ? xw1 : '1;
    xl[1] = xw0[WIDTH-1] ? '0 : xw0;
    xh[1] = xw1;
    yl[0] = yw0;
    yh[0] = yw1[WIDTH-1] ? yw1 : '1;
    yl[1] = yw0[WIDTH-1] ? '0 : yw0;
    yh[1] = yw1;
    xv    = {~xw1[WIDTH-1], xw0[WIDTH-1]};
    yv    = {~yw1[WIDTH-1], yw0[WIDTH-1]};
  end

  // sequencer
  iab_seq #(
    .WIDTH (WIDTH),
    .BW    (BW)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .out_busy  (out_busy),
    .ctrl      (ctrl),
    .bit_pos   (bit_pos)
  );

  // one-hot bit under test, shared by all lanes
  logic [WIDTH-1:0] scan_m;
  assign scan_m = WIDTH'(1) << bit_pos;

  // one lane per pair of parts: lane index is {x part, y part}
  logic [WIDTH-1:0]     lane_lo [NUM_LANES];
  logic [WIDTH-1:0]     lane_hi [NUM_LANES];
  logic [NUM_LANES-1:0] lane_ok_in;
  logic [NUM_LANES-1:0] lane_ok;
  logic                 empty;

  for (genvar p = 0; p < NUM_LANES; p++) begin : g_lane
    assign lane_ok_in[p] = xv[p / 2] & yv[p % 2];

    iab_scan #(
      .WIDTH (WIDTH)
    ) u_scan (
      .clk    (clk),
      .rst    (rst),
      .load   (ctrl.load),
      .step   (ctrl.step),
      .m      (scan_m),
      .a_in   (xl[p / 2]),
      .b_in   (xh[p / 2]),
      .c_in   (yl[p % 2]),
      .d_in   (yh[p % 2]),
      .lo_res (lane_lo[p]),
      .hi_res (lane_hi[p])
    );
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      lane_ok <= lane_ok_in;
      empty   <= empty_in;
    end
  end

  // running min and max in biased (sign-flipped) form, one lane per cycle
  logic [WIDTH-1:0] bmin, bmax, cand_lo, cand_hi;

  assign cand_lo = lane_lo[ctrl.lane] ^ TopBit;
  assign cand_hi = lane_hi[ctrl.lane] ^ TopBit;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      bmin <= '1;
      bmax <= '0;
    end else if (ctrl.comb && lane_ok[ctrl.lane]) begin
      if (cand_lo < bmin) begin
        bmin <= cand_lo;
      end
      if (cand_hi > bmax) begin
        bmax <= cand_hi;
      end
    end
  end

  // back to two's complement, sign extended from WIDTH then cut to the field
  logic signed [WIDTH-1:0] zl_w, zh_w;
  logic signed [63:0]      zl_ext, zh_ext;

  assign zl_w   = bmin ^ TopBit;
  assign zh_w   = bmax ^ TopBit;
  assign zl_ext = 64'(zl_w);
  assign zh_ext = 64'(zh_w);

  // result register parts the scan from the response side
  assign out_busy = rsp_valid && !rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctrl.emit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      z_low  <= empty ? '0 : zl_ext[31:0];
      z_high <= empty ? '0 : zh_ext[31:0];
      z_void <= empty;
    end
  end

endmodule

// ----- rtl/iab_checker.sv -----
// ----------------------------------------------------------------------------
// iab_checker
// port-level checks on the interval and-bounds block, bound to the top level
// ----------------------------------------------------------------------------
`include "interval_and_bounds_top_assert.svh"

module iab_checker #(
  parameter int WIDTH = 32
) (
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_ready,
  input logic               rsp_valid,
  input logic               rsp_ready,
  input logic signed [31:0] z_low,
  input logic signed [31:0] z_high,
  input logic               z_void
);

  // a held response stays offered
  `IAB_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "response dropped while stalled")

  // a held response keeps its payload
  `IAB_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(z_low) && $stable(z_high) && $stable(z_void), "response payload changed while stalled")

  // an empty result carries zero bounds
  `IAB_ASSERT_NOW(a_void_zero, rsp_valid && z_void, z_low == 32'sd0 && z_high == 32'sd0, "empty result with non-zero bounds")

  // bounds are ordered when the field holds the whole datapath value
  `IAB_ASSERT_NOW(a_order, rsp_valid && !z_void && (WIDTH <= 32), z_low <= z_high, "result minimum above maximum")

  // one request at a time: busy right after an accepted request
  `IAB_ASSERT_NEXT(a_busy, req_valid && req_ready, !req_ready, "ready straight after an accepted request")

endmodule

bind interval_and_bounds_top iab_checker #(
  .WIDTH (WIDTH)
) u_iab_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .z_low     (z_low),
  .z_high    (z_high),
  .z_void    (z_void)
);
